// ===== rtl/segx_pkg.sv =====
// ============================================================================
// segx_pkg: shared widths and types for the segment intersection core.
// Holds the field widths, the derived datapath widths and the stage words.
// ============================================================================
package segx_pkg;

    localparam int LON_W  = 32;
    localparam int LAT_W  = 31;
    // Coordinate differences need one more bit than the widest field.
    localparam int DIF_W  = LON_W + 1;
    // Products of two differences, and their difference, plus headroom.
    localparam int PRD_W  = 2 * DIF_W;
    localparam int SUM_W  = PRD_W + 1;
    // Magnitudes of the numerators and the denominator.
    localparam int MAG_W  = SUM_W;
    // Product of the t numerator magnitude and a direction magnitude.
    localparam int NUM_W  = MAG_W + DIF_W;
    // Quotient bits produced by the divider, one per stage.
    localparam int QUO_W  = DIF_W;
    // The t numerator is split into three limbs for the numerator products.
    localparam int LIMB_W = 23;
    localparam int PP_W   = LIMB_W + DIF_W;

    // Word leaving the difference stage.
    typedef struct packed {
        logic signed [LON_W-1:0] p0x;
        logic signed [LAT_W-1:0] p0y;
        logic signed [DIF_W-1:0] d1x;
        logic signed [DIF_W-1:0] d1y;
        logic signed [DIF_W-1:0] d2x;
        logic signed [DIF_W-1:0] d2y;
        logic signed [DIF_W-1:0] wx;
        logic signed [DIF_W-1:0] wy;
    } diff_word_t;

    // Word after the hit decision, going into the divider.
    typedef struct packed {
        logic                    hit;
        logic signed [LON_W-1:0] p0x;
        logic signed [LAT_W-1:0] p0y;
        logic                    neg_x;
        logic                    neg_y;
        logic [MAG_W-1:0]        den;
        logic [NUM_W-1:0]        num_x;
        logic [NUM_W-1:0]        num_y;
    } div_word_t;

endpackage

// ===== rtl/segment_intersection_core.sv =====
// ============================================================================
// segment_intersection_core: exact 2-D segment intersection, fully pipelined.
//
//   Channel   Handshake         Words
//   input     start / busy      eight end point coordinates
//   result    done (strobe)     hit, cross_lon, cross_lat
//
// One word is taken every cycle; busy is always low. A word passes through
// five front stages of products, tests and numerator products, a divider
// load stage, 33 divider stages (one quotient bit each) and a final add.
// Reset clears only the valid bits of the pipeline. The receiver cannot
// stall, so nothing in the pipeline ever waits.
// ============================================================================
module segment_intersection_core
    import segx_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [LON_W-1:0] a_start_lon,
    input  logic signed [LAT_W-1:0] a_start_lat,
    input  logic signed [LON_W-1:0] a_end_lon,
    input  logic signed [LAT_W-1:0] a_end_lat,
    input  logic signed [LON_W-1:0] b_start_lon,
    input  logic signed [LAT_W-1:0] b_start_lat,
    input  logic signed [LON_W-1:0] b_end_lon,
    input  logic signed [LAT_W-1:0] b_end_lat,
    output logic                    done,
    output logic                    hit,
    output logic signed [LON_W-1:0] cross_lon,
    output logic signed [LAT_W-1:0] cross_lat
);

    logic      mid_valid;
    div_word_t mid_word;

    assign busy = 1'b0;

    // Products, sums and the hit test.
    segx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .a_start_lon (a_start_lon),
        .a_start_lat (a_start_lat),
        .a_end_lon   (a_end_lon),
        .a_end_lat   (a_end_lat),
        .b_start_lon (b_start_lon),
        .b_start_lat (b_start_lat),
        .b_end_lon   (b_end_lon),
        .b_end_lat   (b_end_lat),
        .out_valid   (mid_valid),
        .out_word    (mid_word)
    );

    // Quotients and the final point.
    segx_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_word   (mid_word),
        .out_valid (done),
        .out_hit   (hit),
        .out_lon   (cross_lon),
        .out_lat   (cross_lat)
    );

    // A word taken now reaches the divider through the front stages.
    a_front_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 mid_valid)
        else $error("front pipeline lost a word");

    // A miss always reports the origin.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (cross_lon == '0 && cross_lat == '0))
        else $error("miss with nonzero point");

    // Results come only from words taken earlier.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mid_valid) |-> $past(start, 5))
        else $error("word appeared without a start");

endmodule

// ===== rtl/segx_front.sv =====
// ============================================================================
// segx_front: differences, cross products and the hit test.
// Five register stages: differences, products, sums, partial numerator
// products and the summed numerators.
// ============================================================================
module segx_front
    import segx_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [LON_W-1:0] a_start_lon,
    input  logic signed [LAT_W-1:0] a_start_lat,
    input  logic signed [LON_W-1:0] a_end_lon,
    input  logic signed [LAT_W-1:0] a_end_lat,
    input  logic signed [LON_W-1:0] b_start_lon,
    input  logic signed [LAT_W-1:0] b_start_lat,
    input  logic signed [LON_W-1:0] b_end_lon,
    input  logic signed [LAT_W-1:0] b_end_lat,
    output logic                    out_valid,
    output div_word_t               out_word
);

    // Stage 1: coordinate differences.
    logic       s1_valid_reg;
    diff_word_t s1_reg, s1_next;

    always_comb
    begin
        s1_next.p0x = a_start_lon;
        s1_next.p0y = a_start_lat;
        s1_next.d1x = DIF_W'(a_end_lon) - DIF_W'(a_start_lon);
        s1_next.d1y = DIF_W'(a_end_lat) - DIF_W'(a_start_lat);
        s1_next.d2x = DIF_W'(b_end_lon) - DIF_W'(b_start_lon);
        s1_next.d2y = DIF_W'(b_end_lat) - DIF_W'(b_start_lat);
        s1_next.wx  = DIF_W'(a_start_lon) - DIF_W'(b_start_lon);
        s1_next.wy  = DIF_W'(a_start_lat) - DIF_W'(b_start_lat);
    end

    // Stage 2: the six cross products, one multiplier each.
    logic                    s2_valid_reg;
    logic signed [PRD_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [LON_W-1:0] s2_p0x_reg;
    logic signed [LAT_W-1:0] s2_p0y_reg;
    logic signed [DIF_W-1:0] s2_d1x_reg, s2_d1y_reg;

    // Stage 3: exact sums and the hit decision.
    logic                    s3_valid_reg;
    logic signed [SUM_W-1:0] den_next, sn_next, tn_next;
    logic signed [SUM_W-1:0] den_rev_next, sn_rev_next, tn_rev_next;
    logic [MAG_W-1:0]        den_mag_next, sn_mag_next, tn_mag_next;
    logic                    hit_next;
    logic                    s3_hit_reg;
    logic [MAG_W-1:0]        s3_den_reg, s3_tn_reg;
    logic                    s3_negx_reg, s3_negy_reg;
    logic [DIF_W-1:0]        s3_ax_reg, s3_ay_reg;
    logic signed [LON_W-1:0] s3_p0x_reg;
    logic signed [LAT_W-1:0] s3_p0y_reg;

    always_comb
    begin
        // Both orders of each difference are formed side by side, so the
        // magnitude is a select rather than a second carry chain.
        den_next     = SUM_W'(pa_reg) - SUM_W'(pb_reg);
        sn_next      = SUM_W'(pc_reg) - SUM_W'(pd_reg);
        tn_next      = SUM_W'(pe_reg) - SUM_W'(pf_reg);
        den_rev_next = SUM_W'(pb_reg) - SUM_W'(pa_reg);
        sn_rev_next  = SUM_W'(pd_reg) - SUM_W'(pc_reg);
        tn_rev_next  = SUM_W'(pf_reg) - SUM_W'(pe_reg);
        den_mag_next = den_next[SUM_W-1] ? MAG_W'(den_rev_next) : MAG_W'(den_next);
        sn_mag_next  = sn_next[SUM_W-1]  ? MAG_W'(sn_rev_next)  : MAG_W'(sn_next);
        tn_mag_next  = tn_next[SUM_W-1]  ? MAG_W'(tn_rev_next)  : MAG_W'(tn_next);
        // A parameter lies in [0,1] when it is zero or matches the sign and
        // does not exceed the denominator in magnitude.
        hit_next = (den_mag_next != '0)
                && ((sn_mag_next == '0) || ((sn_next[SUM_W-1] == den_next[SUM_W-1])
                    && (sn_mag_next <= den_mag_next)))
                && ((tn_mag_next == '0) || ((tn_next[SUM_W-1] == den_next[SUM_W-1])
                    && (tn_mag_next <= den_mag_next)));
    end

    // Stage 4: each limb of the t numerator times each direction magnitude.
    logic                    s4_valid_reg;
    logic                    s4_hit_reg;
    logic signed [LON_W-1:0] s4_p0x_reg;
    logic signed [LAT_W-1:0] s4_p0y_reg;
    logic                    s4_negx_reg, s4_negy_reg;
    logic [MAG_W-1:0]        s4_den_reg;
    logic [PP_W-1:0]         px0_reg, px1_reg, px2_reg;
    logic [PP_W-1:0]         py0_reg, py1_reg, py2_reg;

    // Stage 5: the partial products summed into the numerators.
    logic      s5_valid_reg;
    div_word_t s5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;

        pa_reg <= s1_reg.d1x * s1_reg.d2y;
        pb_reg <= s1_reg.d2x * s1_reg.d1y;
        pc_reg <= s1_reg.d1x * s1_reg.wy;
        pd_reg <= s1_reg.d1y * s1_reg.wx;
        pe_reg <= s1_reg.d2x * s1_reg.wy;
        pf_reg <= s1_reg.d2y * s1_reg.wx;
        s2_p0x_reg <= s1_reg.p0x;
        s2_p0y_reg <= s1_reg.p0y;
        s2_d1x_reg <= s1_reg.d1x;
        s2_d1y_reg <= s1_reg.d1y;

        s3_hit_reg  <= hit_next;
        s3_den_reg  <= den_mag_next;
        s3_tn_reg   <= tn_mag_next;
        s3_negx_reg <= (tn_next[SUM_W-1] ^ s2_d1x_reg[DIF_W-1]) ^ den_next[SUM_W-1];
        s3_negy_reg <= (tn_next[SUM_W-1] ^ s2_d1y_reg[DIF_W-1]) ^ den_next[SUM_W-1];
        s3_ax_reg   <= s2_d1x_reg[DIF_W-1] ? -s2_d1x_reg : s2_d1x_reg;
        s3_ay_reg   <= s2_d1y_reg[DIF_W-1] ? -s2_d1y_reg : s2_d1y_reg;
        s3_p0x_reg  <= s2_p0x_reg;
        s3_p0y_reg  <= s2_p0y_reg;

        s4_hit_reg  <= s3_hit_reg;
        s4_p0x_reg  <= s3_p0x_reg;
        s4_p0y_reg  <= s3_p0y_reg;
        s4_negx_reg <= s3_negx_reg;
        s4_negy_reg <= s3_negy_reg;
        s4_den_reg  <= s3_den_reg;
        px0_reg <= PP_W'(s3_tn_reg[LIMB_W-1:0]) * PP_W'(s3_ax_reg);
        px1_reg <= PP_W'(s3_tn_reg[2*LIMB_W-1:LIMB_W]) * PP_W'(s3_ax_reg);
        px2_reg <= PP_W'(s3_tn_reg[MAG_W-1:2*LIMB_W]) * PP_W'(s3_ax_reg);
        py0_reg <= PP_W'(s3_tn_reg[LIMB_W-1:0]) * PP_W'(s3_ay_reg);
        py1_reg <= PP_W'(s3_tn_reg[2*LIMB_W-1:LIMB_W]) * PP_W'(s3_ay_reg);
        py2_reg <= PP_W'(s3_tn_reg[MAG_W-1:2*LIMB_W]) * PP_W'(s3_ay_reg);

        s5_reg.hit   <= s4_hit_reg;
        s5_reg.p0x   <= s4_p0x_reg;
        s5_reg.p0y   <= s4_p0y_reg;
        s5_reg.neg_x <= s4_negx_reg;
        s5_reg.neg_y <= s4_negy_reg;
        s5_reg.den   <= s4_den_reg;
        s5_reg.num_x <= NUM_W'(px0_reg) + (NUM_W'(px1_reg) << LIMB_W)
                      + (NUM_W'(px2_reg) << (2 * LIMB_W));
        s5_reg.num_y <= NUM_W'(py0_reg) + (NUM_W'(py1_reg) << LIMB_W)
                      + (NUM_W'(py2_reg) << (2 * LIMB_W));
    end

    assign out_valid = s5_valid_reg;
    assign out_word  = s5_reg;

endmodule

// ===== rtl/segx_divider.sv =====
// ============================================================================
// segx_divider: pipelined restoring divider for both coordinates.
// One quotient bit per stage for each axis, then the signed add to start.
// ============================================================================
module segx_divider
    import segx_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  div_word_t               in_word,
    output logic                    out_valid,
    output logic                    out_hit,
    output logic signed [LON_W-1:0] out_lon,
    output logic signed [LAT_W-1:0] out_lat
);

    // The quotient is below 2^QUO_W, so only the low bits of the dividend
    // enter one at a time; the remainder starts from the high part.
    localparam int REM_W = MAG_W + 1;

    logic [QUO_W:0]   valid_reg;
    div_word_t        word_reg [QUO_W+1];
    logic [REM_W-1:0] rx_reg [QUO_W+1];
    logic [REM_W-1:0] ry_reg [QUO_W+1];
    logic [QUO_W-1:0] qx_reg [QUO_W+1];
    logic [QUO_W-1:0] qy_reg [QUO_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
        end
    end

    // Stage zero loads the high part of the dividend as the remainder.
    always_ff @(posedge clk)
    begin
        word_reg[0] <= in_word;
        rx_reg[0]   <= REM_W'(in_word.num_x[NUM_W-1:QUO_W]);
        ry_reg[0]   <= REM_W'(in_word.num_y[NUM_W-1:QUO_W]);
        qx_reg[0]   <= '0;
        qy_reg[0]   <= '0;
    end

    // One shift and trial subtract per stage.
    for (genvar g = 0; g < QUO_W; g++)
    begin : g_step
        logic [REM_W-1:0] tx_next, ty_next;
        always_comb
        begin
            tx_next = {rx_reg[g][REM_W-2:0], word_reg[g].num_x[QUO_W-1-g]};
            ty_next = {ry_reg[g][REM_W-2:0], word_reg[g].num_y[QUO_W-1-g]};
        end
        always_ff @(posedge clk)
        begin
            word_reg[g+1] <= word_reg[g];
            if (tx_next >= REM_W'(word_reg[g].den))
            begin
                rx_reg[g+1] <= tx_next - REM_W'(word_reg[g].den);
                qx_reg[g+1] <= {qx_reg[g][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rx_reg[g+1] <= tx_next;
                qx_reg[g+1] <= {qx_reg[g][QUO_W-2:0], 1'b0};
            end
            if (ty_next >= REM_W'(word_reg[g].den))
            begin
                ry_reg[g+1] <= ty_next - REM_W'(word_reg[g].den);
                qy_reg[g+1] <= {qy_reg[g][QUO_W-2:0], 1'b1};
            end
            else
            begin
                ry_reg[g+1] <= ty_next;
                qy_reg[g+1] <= {qy_reg[g][QUO_W-2:0], 1'b0};
            end
        end
    end

    // Final stage: apply the sign and add the start point; a miss gives zero.
    logic                    hit_reg;
    logic signed [LON_W-1:0] lon_reg, lon_next;
    logic signed [LAT_W-1:0] lat_reg, lat_next;
    logic                    fin_valid_reg;

    always_comb
    begin
        lon_next = word_reg[QUO_W].neg_x
                 ? word_reg[QUO_W].p0x - LON_W'(qx_reg[QUO_W])
                 : word_reg[QUO_W].p0x + LON_W'(qx_reg[QUO_W]);
        lat_next = word_reg[QUO_W].neg_y
                 ? word_reg[QUO_W].p0y - LAT_W'(qy_reg[QUO_W])
                 : word_reg[QUO_W].p0y + LAT_W'(qy_reg[QUO_W]);
        if (!word_reg[QUO_W].hit)
        begin
            lon_next = '0;
            lat_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= valid_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= word_reg[QUO_W].hit;
        lon_reg <= lon_next;
        lat_reg <= lat_next;
    end

    assign out_valid = fin_valid_reg;
    assign out_hit   = hit_reg;
    assign out_lon   = lon_reg;
    assign out_lat   = lat_reg;

endmodule

// ===== tb/tb_segment_intersection_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Segment intersection core testbench
// Drives segment pairs through the start/busy port with random gaps and
// checks every done strobe against a bit-exact predictor that works in
// wide signed arithmetic, oldest expectation first.
// ============================================================================
module tb_segment_intersection_core;
    import segx_pkg::*;

    typedef struct {
        logic signed [LON_W-1:0] p0x;
        logic signed [LAT_W-1:0] p0y;
        logic signed [LON_W-1:0] p1x;
        logic signed [LAT_W-1:0] p1y;
        logic signed [LON_W-1:0] p2x;
        logic signed [LAT_W-1:0] p2y;
        logic signed [LON_W-1:0] p3x;
        logic signed [LAT_W-1:0] p3y;
    } seg_pair_t;

    typedef struct {
        logic                    hit;
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
    } crossing_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy, done, hit;
    logic signed [LON_W-1:0] a_start_lon = 0, a_end_lon = 0, b_start_lon = 0, b_end_lon = 0;
    logic signed [LAT_W-1:0] a_start_lat = 0, a_end_lat = 0, b_start_lat = 0, b_end_lat = 0;
    logic signed [LON_W-1:0] cross_lon;
    logic signed [LAT_W-1:0] cross_lat;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int errors = 0;
    int hits_seen = 0;
    int words_sent = 0;
    int gap_left = 0;
    int idle_cycles = 0;
    bit stimulus_done = 0;

    segment_intersection_core dut (.*);

    always #1 clk = ~clk;

    // Exact prediction; 160-bit signed math covers every intermediate.
    function automatic crossing_t predict_crossing(seg_pair_t s);
        logic signed [159:0] d1x, d1y, d2x, d2y, wx, wy, den, sn, tn, qx, qy;
        crossing_t r;
        d1x = s.p1x - s.p0x;  d1y = s.p1y - s.p0y;
        d2x = s.p3x - s.p2x;  d2y = s.p3y - s.p2y;
        d1x = 160'(s.p1x) - 160'(s.p0x);
        d1y = 160'(s.p1y) - 160'(s.p0y);
        d2x = 160'(s.p3x) - 160'(s.p2x);
        d2y = 160'(s.p3y) - 160'(s.p2y);
        wx = 160'(s.p0x) - 160'(s.p2x);
        wy = 160'(s.p0y) - 160'(s.p2y);
        den = d1x * d2y - d2x * d1y;
        sn = d1x * wy - d1y * wx;
        tn = d2x * wy - d2y * wx;
        r.hit = 0; r.lon = 0; r.lat = 0;
        if (den != 0
            && (sn == 0 || ((sn < 0) == (den < 0) && (sn < 0 ? -sn : sn) <= (den < 0 ? -den : den)))
            && (tn == 0 || ((tn < 0) == (den < 0) && (tn < 0 ? -tn : tn) <= (den < 0 ? -den : den))))
        begin
            // Signed division truncates toward zero, as required.
            qx = (tn * d1x) / den;
            qy = (tn * d1y) / den;
            r.hit = 1;
            r.lon = LON_W'(160'(s.p0x) + qx);
            r.lat = LAT_W'(160'(s.p0y) + qy);
        end
        return r;
    endfunction

    function automatic logic signed [LON_W-1:0] rand_lon();
        return $signed(32'($urandom_range(0, 3600000000))) - 32'sd1800000000;
    endfunction

    function automatic logic signed [LAT_W-1:0] rand_lat();
        return LAT_W'($signed(32'($urandom_range(0, 1800000000))) - 32'sd900000000);
    endfunction

    // Queue one pair by its points.
    task automatic add_pair(longint ax0, longint ay0, longint ax1, longint ay1,
                            longint bx0, longint by0, longint bx1, longint by1);
        seg_pair_t s;
        s.p0x = LON_W'(ax0); s.p0y = LAT_W'(ay0);
        s.p1x = LON_W'(ax1); s.p1y = LAT_W'(ay1);
        s.p2x = LON_W'(bx0); s.p2y = LAT_W'(by0);
        s.p3x = LON_W'(bx1); s.p3y = LAT_W'(by1);
        pending_pairs.push_back(s);
    endtask

    // Driver: a word moves at an edge with start high and busy low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_crossings.push_back(predict_crossing(pending_pairs.pop_front()));
                words_sent++;
                gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            end
            if (!(start && busy))
            begin
                if (gap_left > 0 || pending_pairs.size() == 0)
                begin
                    if (gap_left > 0) gap_left--;
                    start <= 0;
                end
                else
                begin
                    start       <= 1;
                    a_start_lon <= pending_pairs[0].p0x;
                    a_start_lat <= pending_pairs[0].p0y;
                    a_end_lon   <= pending_pairs[0].p1x;
                    a_end_lat   <= pending_pairs[0].p1y;
                    b_start_lon <= pending_pairs[0].p2x;
                    b_start_lat <= pending_pairs[0].p2y;
                    b_end_lon   <= pending_pairs[0].p3x;
                    b_end_lat   <= pending_pairs[0].p3y;
                end
            end
        end
    end

    // Monitor: compare each strobed word with the oldest expectation.
    always @(posedge clk)
    begin
        crossing_t e;
        if (rst_n && done)
        begin
            if (expected_crossings.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b lon=%0d lat=%0d",
                         $time, hit, cross_lon, cross_lat);
                errors++;
            end
            else
            begin
                e = expected_crossings.pop_front();
                if (hit) hits_seen++;
                if (hit !== e.hit || cross_lon !== e.lon || cross_lat !== e.lat)
                begin
                    $display("%0t: expected hit=%0b lon=%0d lat=%0d, actual hit=%0b lon=%0d lat=%0d",
                             $time, e.hit, e.lon, e.lat, hit, cross_lon, cross_lat);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word in either direction.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("segment_intersection_core verification failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        longint x0, y0, dx, dy, ex, ey;
        int k;
        // Directed: crossing, touching ends, parallel, collinear, extremes.
        add_pair(0, 0, 100, 100, 0, 100, 100, 0);
        add_pair(0, 0, 100, 0, 100, 0, 100, 50);
        add_pair(0, 0, 100, 0, 0, 10, 100, 10);
        add_pair(0, 0, 100, 0, 50, 0, 150, 0);
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 10, 10, 20, 0, 30, -10);
        add_pair(-1800000000, -900000000, 1800000000, 900000000,
                 -1800000000, 900000000, 1800000000, -900000000);
        add_pair(1800000000, 900000000, -1800000000, -900000000,
                 1800000000, -900000000, -1800000000, 900000000);
        add_pair(-2147483648, -1073741824, 2147483647, 1073741823,
                 2147483647, -1073741824, -2147483648, 1073741823);
        add_pair(-2147483648, 1073741823, 2147483647, -1073741824,
                 -2147483648, -1073741824, 2147483647, 1073741823);
        add_pair(-1, -1, 3, 2, 3, -1, -1, 2);
        add_pair(0, 0, 7, 3, 7, 3, -5, 9);
        add_pair(10, 10, 0, 0, 5, 5, 10, 0);
        add_pair(0, 0, 1, 0, 0, 1, 1, 2);
        add_pair(-7, 5, 9, -3, 11, 11, -13, -13);
        // Random: half close crossing pairs, the rest wide, a fifth of them unconstrained.
        for (k = 0; k < 540; k++)
        begin
            if (k % 2 == 0)
            begin
                x0 = longint'(rand_lon()) / 2; y0 = longint'(rand_lat()) / 2;
                dx = $signed($urandom_range(0, 2000)) - 1000;
                dy = $signed($urandom_range(0, 2000)) - 1000;
                ex = $signed($urandom_range(0, 2000)) - 1000;
                ey = $signed($urandom_range(0, 2000)) - 1000;
                add_pair(x0 - dx, y0 - dy, x0 + dx, y0 + dy, x0 - ex, y0 - ey, x0 + ex, y0 + ey);
            end
            else if (k % 10 == 1)
                add_pair($signed($urandom()), $signed($urandom()), $signed($urandom()),
                         $signed($urandom()), $signed($urandom()), $signed($urandom()),
                         $signed($urandom()), $signed($urandom()));
            else
                add_pair(rand_lon(), rand_lat(), rand_lon(), rand_lat(),
                         rand_lon(), rand_lat(), rand_lon(), rand_lat());
        end
        repeat (9) @(posedge clk);
        rst_n <= 1;
        wait (pending_pairs.size() == 0 && !start);
        wait (expected_crossings.size() == 0);
        repeat (60) @(posedge clk);
        $display("Sent %0d segment pairs including directed edge cases;", words_sent);
        $display("%0d of the results were hits.", hits_seen);
        if (errors == 0 && expected_crossings.size() == 0)
            $display("segment_intersection_core verification clean");
        else
            $display("segment_intersection_core verification failed");
        $finish;
    end
endmodule
